FILE: hdl/aslbl_pkg.sv
package aslbl_pkg;

   localparam int NUM_AXES   = 10;
   localparam int NUM_LOCKS  = 4;
   localparam int REG_W      = 24;
   localparam int ELAPSED_W  = 16;
   localparam int FLAGS_W    = 6;
   localparam int BUTTONS_W  = 5;
   localparam int FRAC_BITS  = 16;
   localparam int PRODUCT_W  = REG_W + ELAPSED_W;
   localparam int STEP_W     = PRODUCT_W - FRAC_BITS;
   localparam int CSR_IDX_W  = 3;

   // axes 0..1 drive, 2..3 turn, 4..9 air
   localparam int FIRST_TURN = 2;
   localparam int FIRST_AIR  = 4;

   localparam int FLAG_MENU   = 0;
   localparam int FLAG_IN_AIR = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL_RATE   = 3'd0,
      CSR_TURN_RATE    = 3'd1,
      CSR_AIR_RATE     = 3'd2,
      CSR_POWERUP_HOLD = 3'd3,
      CSR_JUMP_HOLD    = 3'd4,
      CSR_CHEAT_HOLD   = 3'd5,
      CSR_DEBUG_HOLD   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [REG_W-1:0] accel;
      logic [REG_W-1:0] turn;
      logic [REG_W-1:0] air;
   } rates_type;

   typedef struct packed {
      logic [STEP_W-1:0] drive;
      logic [STEP_W-1:0] turn;
      logic [STEP_W-1:0] air;
   } steps_type;

   typedef struct packed {
      logic advance;
      logic bypass;
   } lane_ctl_type;

endpackage

FILE: hdl/aslbl_if.sv
interface aslbl_req_if #(parameter int AXIS_BITS = 16) ();
   logic                                    valid;
   logic                                    ready;
   logic [aslbl_pkg::ELAPSED_W-1:0]         elapsed;
   logic [aslbl_pkg::FLAGS_W-1:0]           flags;
   logic signed [AXIS_BITS-1:0]             fwd_in;
   logic signed [AXIS_BITS-1:0]             back_in;
   logic signed [AXIS_BITS-1:0]             turn_left_in;
   logic signed [AXIS_BITS-1:0]             turn_right_in;
   logic signed [AXIS_BITS-1:0]             tilt_fwd_in;
   logic signed [AXIS_BITS-1:0]             tilt_back_in;
   logic signed [AXIS_BITS-1:0]             roll_left_in;
   logic signed [AXIS_BITS-1:0]             roll_right_in;
   logic signed [AXIS_BITS-1:0]             spin_left_in;
   logic signed [AXIS_BITS-1:0]             spin_right_in;

   modport source (
      output valid, elapsed, flags, fwd_in, back_in, turn_left_in, turn_right_in,
             tilt_fwd_in, tilt_back_in, roll_left_in, roll_right_in, spin_left_in,
             spin_right_in,
      input  ready
   );
   modport sink (
      input  valid, elapsed, flags, fwd_in, back_in, turn_left_in, turn_right_in,
             tilt_fwd_in, tilt_back_in, roll_left_in, roll_right_in, spin_left_in,
             spin_right_in,
      output ready
   );
endinterface

interface aslbl_rsp_if #(parameter int AXIS_BITS = 16) ();
   logic                                    valid;
   logic                                    ready;
   logic [aslbl_pkg::BUTTONS_W-1:0]         buttons_out;
   logic signed [AXIS_BITS-1:0]             fwd_out;
   logic signed [AXIS_BITS-1:0]             back_out;
   logic signed [AXIS_BITS-1:0]             turn_left_out;
   logic signed [AXIS_BITS-1:0]             turn_right_out;
   logic signed [AXIS_BITS-1:0]             tilt_fwd_out;
   logic signed [AXIS_BITS-1:0]             tilt_back_out;
   logic signed [AXIS_BITS-1:0]             roll_left_out;
   logic signed [AXIS_BITS-1:0]             roll_right_out;
   logic signed [AXIS_BITS-1:0]             spin_left_out;
   logic signed [AXIS_BITS-1:0]             spin_right_out;

   modport source (
      output valid, buttons_out, fwd_out, back_out, turn_left_out, turn_right_out,
             tilt_fwd_out, tilt_back_out, roll_left_out, roll_right_out,
             spin_left_out, spin_right_out,
      input  ready
   );
   modport sink (
      input  valid, buttons_out, fwd_out, back_out, turn_left_out, turn_right_out,
             tilt_fwd_out, tilt_back_out, roll_left_out, roll_right_out,
             spin_left_out, spin_right_out,
      output ready
   );
endinterface

interface aslbl_csr_if ();
   logic                              valid;
   logic                              ready;
   logic [aslbl_pkg::CSR_IDX_W-1:0]   index;
   logic [aslbl_pkg::REG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/axis_slew_limiter_button_lockout.sv
// Channel  Direction  Handshake     Payload
// req_if   in         valid/ready   elapsed, flags, ten axis inputs
// rsp_if   out        valid/ready   buttons_out, ten axis outputs
// csr_if   in         valid/ready   index, data (always ready)
//
// Two stages: the step multipliers register the allowed step per rate class,
// then ten slew lanes and the button logic update state and load the output
// register. One transaction per cycle while the output is not stalled.
// Synchronous reset clears the config registers, axis history, time and locks.
// A stalled output holds; the input stage keeps accepting until both stages fill.
module axis_slew_limiter_button_lockout #(
   parameter int AXIS_BITS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   aslbl_req_if.sink      req_if,
   aslbl_rsp_if.source    rsp_if,
   aslbl_csr_if.sink      csr_if
);

   aslbl_pkg::rates_type            rates_ff;
   logic [aslbl_pkg::REG_W-1:0]     holds_ff [aslbl_pkg::NUM_LOCKS];

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic [AXIS_BITS-1:0]            s1_axis_ff [aslbl_pkg::NUM_AXES];
   logic [aslbl_pkg::FLAGS_W-1:0]   s1_flags_ff;
   logic [aslbl_pkg::ELAPSED_W-1:0] s1_elapsed_ff;
   aslbl_pkg::steps_type            s1_steps;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [AXIS_BITS-1:0]            rsp_axis_ff [aslbl_pkg::NUM_AXES];
   logic [aslbl_pkg::BUTTONS_W-1:0] rsp_buttons_ff;

   logic                            load;
   logic                            advance;
   logic                            s1_ready;
   logic                            s2_ready;
   logic [AXIS_BITS-1:0]            req_axis [aslbl_pkg::NUM_AXES];
   logic [AXIS_BITS-1:0]            lane_res [aslbl_pkg::NUM_AXES];
   logic [aslbl_pkg::BUTTONS_W-1:0] buttons;

   assign req_axis[0] = req_if.fwd_in;
   assign req_axis[1] = req_if.back_in;
   assign req_axis[2] = req_if.turn_left_in;
   assign req_axis[3] = req_if.turn_right_in;
   assign req_axis[4] = req_if.tilt_fwd_in;
   assign req_axis[5] = req_if.tilt_back_in;
   assign req_axis[6] = req_if.roll_left_in;
   assign req_axis[7] = req_if.roll_right_in;
   assign req_axis[8] = req_if.spin_left_in;
   assign req_axis[9] = req_if.spin_right_in;

   // pipeline handshake
   assign s2_ready     = ~rsp_valid_ff | rsp_if.ready;
   assign advance      = s1_valid_ff & s2_ready;
   assign s1_ready     = ~s1_valid_ff | s2_ready;
   assign req_if.ready = s1_ready;
   assign load         = req_if.valid & s1_ready;

   assign s1_valid_in  = load | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_if.ready);

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rates_ff <= '0;
         for (int i = 0; i < aslbl_pkg::NUM_LOCKS; i++) begin
            holds_ff[i] <= '0;
         end
      end else if (csr_if.valid) begin
         unique case (aslbl_pkg::csr_index_type'(csr_if.index))
            aslbl_pkg::CSR_ACCEL_RATE:   rates_ff.accel <= csr_if.data;
            aslbl_pkg::CSR_TURN_RATE:    rates_ff.turn  <= csr_if.data;
            aslbl_pkg::CSR_AIR_RATE:     rates_ff.air   <= csr_if.data;
            aslbl_pkg::CSR_POWERUP_HOLD: holds_ff[0]    <= csr_if.data;
            aslbl_pkg::CSR_JUMP_HOLD:    holds_ff[1]    <= csr_if.data;
            aslbl_pkg::CSR_CHEAT_HOLD:   holds_ff[2]    <= csr_if.data;
            aslbl_pkg::CSR_DEBUG_HOLD:   holds_ff[3]    <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_flags_ff   <= req_if.flags;
         s1_elapsed_ff <= req_if.elapsed;
         for (int i = 0; i < aslbl_pkg::NUM_AXES; i++) begin
            s1_axis_ff[i] <= req_axis[i];
         end
      end
   end

   aslbl_step u_step (
      .clock   (clock),
      .load    (load),
      .rates   (rates_ff),
      .elapsed (req_if.elapsed),
      .steps   (s1_steps)
   );

   for (genvar g = 0; g < aslbl_pkg::NUM_AXES; g++) begin : g_lane
      aslbl_pkg::lane_ctl_type     ctl;
      logic [aslbl_pkg::STEP_W-1:0] step;

      always_comb begin
         ctl.advance = advance;
         if (g < aslbl_pkg::FIRST_TURN) begin
            step       = s1_steps.drive;
            ctl.bypass = 1'b0;
         end else if (g < aslbl_pkg::FIRST_AIR) begin
            step       = s1_steps.turn;
            ctl.bypass = 1'b0;
         end else begin
            // on the ground air axes pass through and forget history
            step       = s1_steps.air;
            ctl.bypass = ~s1_flags_ff[aslbl_pkg::FLAG_IN_AIR];
         end
      end

      aslbl_lane #(
         .AXIS_BITS (AXIS_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .step   (step),
         .target (s1_axis_ff[g]),
         .result (lane_res[g])
      );
   end

   aslbl_buttons #(
      .TIME_BITS (TIME_BITS)
   ) u_buttons (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .elapsed (s1_elapsed_ff),
      .press   (s1_flags_ff[aslbl_pkg::BUTTONS_W-1:0]),
      .holds   (holds_ff),
      .buttons (buttons)
   );

   // merge lane results and buttons into the output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_buttons_ff <= buttons;
         for (int i = 0; i < aslbl_pkg::NUM_AXES; i++) begin
            rsp_axis_ff[i] <= lane_res[i];
         end
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.buttons_out    = rsp_buttons_ff;
   assign rsp_if.fwd_out        = rsp_axis_ff[0];
   assign rsp_if.back_out       = rsp_axis_ff[1];
   assign rsp_if.turn_left_out  = rsp_axis_ff[2];
   assign rsp_if.turn_right_out = rsp_axis_ff[3];
   assign rsp_if.tilt_fwd_out   = rsp_axis_ff[4];
   assign rsp_if.tilt_back_out  = rsp_axis_ff[5];
   assign rsp_if.roll_left_out  = rsp_axis_ff[6];
   assign rsp_if.roll_right_out = rsp_axis_ff[7];
   assign rsp_if.spin_left_out  = rsp_axis_ff[8];
   assign rsp_if.spin_right_out = rsp_axis_ff[9];

endmodule

FILE: hdl/aslbl_step.sv
module aslbl_step (
   input  logic                              clock,
   input  logic                              load,
   input  aslbl_pkg::rates_type              rates,
   input  logic [aslbl_pkg::ELAPSED_W-1:0]   elapsed,
   output aslbl_pkg::steps_type              steps
);

   logic [aslbl_pkg::PRODUCT_W-1:0] prod_drive;
   logic [aslbl_pkg::PRODUCT_W-1:0] prod_turn;
   logic [aslbl_pkg::PRODUCT_W-1:0] prod_air;
   aslbl_pkg::steps_type            steps_ff;
   aslbl_pkg::steps_type            steps_in;

   // Q8.16 rate times whole time units, drop the fraction
   assign prod_drive = aslbl_pkg::PRODUCT_W'(rates.accel) * aslbl_pkg::PRODUCT_W'(elapsed);
   assign prod_turn  = aslbl_pkg::PRODUCT_W'(rates.turn) * aslbl_pkg::PRODUCT_W'(elapsed);
   assign prod_air   = aslbl_pkg::PRODUCT_W'(rates.air) * aslbl_pkg::PRODUCT_W'(elapsed);

   always_comb begin
      steps_in.drive = prod_drive[aslbl_pkg::PRODUCT_W-1:aslbl_pkg::FRAC_BITS];
      steps_in.turn  = prod_turn[aslbl_pkg::PRODUCT_W-1:aslbl_pkg::FRAC_BITS];
      steps_in.air   = prod_air[aslbl_pkg::PRODUCT_W-1:aslbl_pkg::FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         steps_ff <= steps_in;
      end
   end

   assign steps = steps_ff;

endmodule

FILE: hdl/aslbl_lane.sv
module aslbl_lane #(
   parameter int AXIS_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  aslbl_pkg::lane_ctl_type          ctl,
   input  logic [aslbl_pkg::STEP_W-1:0]     step,
   input  logic [AXIS_BITS-1:0]             target,
   output logic [AXIS_BITS-1:0]             result
);

   localparam int WIDE_W = AXIS_BITS + 1;
   localparam int CMP_W  = (WIDE_W > aslbl_pkg::STEP_W) ? WIDE_W : aslbl_pkg::STEP_W;

   logic [AXIS_BITS-1:0] prev_ff;
   logic [AXIS_BITS-1:0] prev_in;
   logic [WIDE_W-1:0]    last_x;
   logic [WIDE_W-1:0]    target_x;
   logic [WIDE_W-1:0]    delta;
   logic [WIDE_W-1:0]    mag;
   logic [WIDE_W-1:0]    step_x;
   logic [WIDE_W-1:0]    moved;
   logic                 rising;
   logic                 limited;
   logic [AXIS_BITS-1:0] slewed;

   assign last_x   = {prev_ff[AXIS_BITS-1], prev_ff};
   assign target_x = {target[AXIS_BITS-1], target};
   assign delta    = target_x - last_x;
   assign rising   = ~delta[WIDE_W-1];
   assign mag      = rising ? delta : (~delta + WIDE_W'(1));
   assign limited  = CMP_W'(mag) > CMP_W'(step);
   // step stays below the distance when limited, so it fits here
   assign step_x   = WIDE_W'(step);
   assign moved    = rising ? (last_x + step_x) : (last_x - step_x);
   assign slewed   = limited ? moved[AXIS_BITS-1:0] : target;

   always_comb begin
      if (ctl.bypass) begin
         result  = target;
         prev_in = '0;
      end else begin
         result  = slewed;
         prev_in = slewed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (ctl.advance) begin
         prev_ff <= prev_in;
      end
   end

endmodule

FILE: hdl/aslbl_buttons.sv
module aslbl_buttons #(
   parameter int TIME_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [aslbl_pkg::ELAPSED_W-1:0]    elapsed,
   input  logic [aslbl_pkg::BUTTONS_W-1:0]    press,
   input  logic [aslbl_pkg::REG_W-1:0]        holds [aslbl_pkg::NUM_LOCKS],
   output logic [aslbl_pkg::BUTTONS_W-1:0]    buttons
);

   localparam int CMP_W = (TIME_BITS > aslbl_pkg::REG_W) ? TIME_BITS : aslbl_pkg::REG_W;

   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] now_in;
   logic                 menu_held_ff;
   logic [aslbl_pkg::NUM_LOCKS-1:0] active_ff;
   logic [aslbl_pkg::NUM_LOCKS-1:0] active_in;
   logic [TIME_BITS-1:0] start_ff [aslbl_pkg::NUM_LOCKS];
   logic [TIME_BITS-1:0] start_in [aslbl_pkg::NUM_LOCKS];
   logic [TIME_BITS-1:0] since    [aslbl_pkg::NUM_LOCKS];

   assign now_in = now_ff + TIME_BITS'(elapsed);

   always_comb begin
      buttons = '0;
      buttons[aslbl_pkg::FLAG_MENU] = press[aslbl_pkg::FLAG_MENU] & ~menu_held_ff;
      for (int i = 0; i < aslbl_pkg::NUM_LOCKS; i++) begin
         since[i]     = now_in - start_ff[i];
         active_in[i] = active_ff[i];
         start_in[i]  = start_ff[i];
         priority if (press[i+1] && !active_ff[i]) begin
            active_in[i]  = 1'b1;
            start_in[i]   = now_in;
            buttons[i+1]  = 1'b1;
         end else if (active_ff[i]) begin
            // blocked on the expiring item too; release for the next one
            if (CMP_W'(since[i]) >= CMP_W'(holds[i])) begin
               active_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         menu_held_ff <= 1'b0;
         active_ff    <= '0;
         for (int i = 0; i < aslbl_pkg::NUM_LOCKS; i++) begin
            start_ff[i] <= '0;
         end
      end else if (advance) begin
         now_ff       <= now_in;
         menu_held_ff <= press[aslbl_pkg::FLAG_MENU];
         active_ff    <= active_in;
         for (int i = 0; i < aslbl_pkg::NUM_LOCKS; i++) begin
            start_ff[i] <= start_in[i];
         end
      end
   end

endmodule
